// ===== rtl/wcvps_pkg.sv =====
// ----------------------------------------------------------------------------
// wcvps_pkg
// shared codes and types of the windowed closest-value pixel search
// ----------------------------------------------------------------------------
package wcvps_pkg;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HALF_WIDTH   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HALF_HEIGHT  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TARGET_VALUE = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_MAX_X  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_MAX_Y  = 3'd4;

    // item kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    localparam int unsigned VALUE_BITS = 8;
    localparam int unsigned HALF_RESET = 7;
    localparam logic [VALUE_BITS-1:0] TARGET_RESET = 8'd0;
    localparam logic [VALUE_BITS-1:0] DIFF_RESET   = 8'hff;

    // classification of one item, handed from front to back
    typedef struct packed {
        logic kind;
        logic in_window;
        logic last;
    } t_flags;

    localparam int unsigned FLAGS_BITS = $bits(t_flags);

endpackage

// ===== rtl/wcvps_queue.sv =====
// ----------------------------------------------------------------------------
// wcvps_queue
// small first-in first-out queue with full and empty flags
// ----------------------------------------------------------------------------
module wcvps_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int unsigned PTR_BITS = $clog2(DEPTH);
    localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;
    logic                w_push;
    logic                w_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/wcvps_front.sv =====
// ----------------------------------------------------------------------------
// wcvps_front
// holds the configuration and the window center, classifies each item
// ----------------------------------------------------------------------------
module wcvps_front #(
    parameter int unsigned COORD_BITS       = 12,
    parameter int unsigned HALF_WINDOW_BITS = 6,
    parameter int unsigned CFG_BITS         = 12,
    parameter int unsigned DIST_BITS        = 13
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [wcvps_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_BITS-1:0]                   i_cfg_data,
    input  logic                                  i_accept,
    input  logic                                  i_kind,
    input  logic [COORD_BITS-1:0]                 i_pos_x,
    input  logic [COORD_BITS-1:0]                 i_pos_y,
    input  logic [wcvps_pkg::VALUE_BITS-1:0]      i_pixel_value,
    input  logic                                  i_last_pixel,
    output wcvps_pkg::t_flags                     o_flags,
    output logic [wcvps_pkg::VALUE_BITS-1:0]      o_diff,
    output logic [DIST_BITS-1:0]                  o_dist
);

    localparam int unsigned CMP_BITS =
        (COORD_BITS > HALF_WINDOW_BITS) ? COORD_BITS : HALF_WINDOW_BITS;
    localparam logic [HALF_WINDOW_BITS-1:0] HALF_RST =
        HALF_WINDOW_BITS'(wcvps_pkg::HALF_RESET & ((1 << HALF_WINDOW_BITS) - 1));

    logic [HALF_WINDOW_BITS-1:0]          r_half_width;
    logic [HALF_WINDOW_BITS-1:0]          r_half_height;
    logic [wcvps_pkg::VALUE_BITS-1:0]     r_target;
    logic [COORD_BITS-1:0]                r_frame_max_x;
    logic [COORD_BITS-1:0]                r_frame_max_y;
    logic [COORD_BITS-1:0]                r_center_x;
    logic [COORD_BITS-1:0]                r_center_y;

    logic [COORD_BITS-1:0]                w_dx;
    logic [COORD_BITS-1:0]                w_dy;
    logic [CMP_BITS-1:0]                  w_dx_cmp;
    logic [CMP_BITS-1:0]                  w_dy_cmp;
    logic [DIST_BITS-1:0]                 w_dx_sq;
    logic [DIST_BITS-1:0]                 w_dy_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_width  <= HALF_RST;
            r_half_height <= HALF_RST;
            r_target      <= wcvps_pkg::TARGET_RESET;
            r_frame_max_x <= '1;
            r_frame_max_y <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                wcvps_pkg::CFG_HALF_WIDTH: begin
                    r_half_width <= i_cfg_data[HALF_WINDOW_BITS-1:0];
                end
                wcvps_pkg::CFG_HALF_HEIGHT: begin
                    r_half_height <= i_cfg_data[HALF_WINDOW_BITS-1:0];
                end
                wcvps_pkg::CFG_TARGET_VALUE: begin
                    r_target <= i_cfg_data[wcvps_pkg::VALUE_BITS-1:0];
                end
                wcvps_pkg::CFG_FRAME_MAX_X: begin
                    r_frame_max_x <= i_cfg_data[COORD_BITS-1:0];
                end
                wcvps_pkg::CFG_FRAME_MAX_Y: begin
                    r_frame_max_y <= i_cfg_data[COORD_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // center is tracked here so that pixels behind a start item see it at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
        end else if (i_accept && (i_kind == wcvps_pkg::KIND_START)) begin
            r_center_x <= i_pos_x;
            r_center_y <= i_pos_y;
        end
    end

    always_comb begin
        o_diff = (i_pixel_value >= r_target) ? (i_pixel_value - r_target)
                                             : (r_target - i_pixel_value);
        w_dx = (i_pos_x >= r_center_x) ? (i_pos_x - r_center_x) : (r_center_x - i_pos_x);
        w_dy = (i_pos_y >= r_center_y) ? (i_pos_y - r_center_y) : (r_center_y - i_pos_y);
        w_dx_cmp = CMP_BITS'(w_dx);
        w_dy_cmp = CMP_BITS'(w_dy);

        o_flags.kind      = i_kind;
        o_flags.last      = i_last_pixel;
        o_flags.in_window = (w_dx_cmp <= CMP_BITS'(r_half_width))
                         && (w_dy_cmp <= CMP_BITS'(r_half_height))
                         && (i_pos_x <= r_frame_max_x)
                         && (i_pos_y <= r_frame_max_y);

        // offsets stay within the half size whenever the pixel is inside
        w_dx_sq = DIST_BITS'(w_dx_cmp[HALF_WINDOW_BITS-1:0])
                * DIST_BITS'(w_dx_cmp[HALF_WINDOW_BITS-1:0]);
        w_dy_sq = DIST_BITS'(w_dy_cmp[HALF_WINDOW_BITS-1:0])
                * DIST_BITS'(w_dy_cmp[HALF_WINDOW_BITS-1:0]);
        o_dist  = w_dx_sq + w_dy_sq;
    end

endmodule

// ===== rtl/wcvps_back.sv =====
// ----------------------------------------------------------------------------
// wcvps_back
// keeps the best candidate and emits it on the last item of a search
// ----------------------------------------------------------------------------
module wcvps_back #(
    parameter int unsigned COORD_BITS = 12,
    parameter int unsigned DIST_BITS  = 13,
    parameter int unsigned MID_BITS   = 48,
    parameter int unsigned RES_BITS   = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [MID_BITS-1:0] i_mid_data,
    input  logic                i_mid_empty,
    output logic                o_mid_pop,
    input  logic                i_res_full,
    output logic                o_res_push,
    output logic [RES_BITS-1:0] o_res_data
);

    localparam int unsigned VB = wcvps_pkg::VALUE_BITS;

    wcvps_pkg::t_flags         w_flags;
    logic [COORD_BITS-1:0]     w_x;
    logic [COORD_BITS-1:0]     w_y;
    logic [VB-1:0]             w_diff;
    logic [DIST_BITS-1:0]      w_dist;
    logic                      w_better;

    logic [COORD_BITS-1:0]     r_chosen_x;
    logic [COORD_BITS-1:0]     r_chosen_y;
    logic [VB-1:0]             r_chosen_diff;
    logic [DIST_BITS-1:0]      r_chosen_dist;
    logic [COORD_BITS-1:0]     n_chosen_x;
    logic [COORD_BITS-1:0]     n_chosen_y;
    logic [VB-1:0]             n_chosen_diff;
    logic [DIST_BITS-1:0]      n_chosen_dist;

    assign {w_flags, w_x, w_y, w_diff, w_dist} = i_mid_data;

    always_comb begin
        n_chosen_x    = r_chosen_x;
        n_chosen_y    = r_chosen_y;
        n_chosen_diff = r_chosen_diff;
        n_chosen_dist = r_chosen_dist;
        // a last item needs room in the result queue, any other goes straight on
        o_mid_pop = !i_mid_empty && (!w_flags.last || !i_res_full);
        w_better  = (w_diff < r_chosen_diff)
                 || ((w_diff == r_chosen_diff) && (w_dist < r_chosen_dist));
        if (w_flags.kind == wcvps_pkg::KIND_START) begin
            n_chosen_x    = w_x;
            n_chosen_y    = w_y;
            n_chosen_diff = w_diff;
            n_chosen_dist = '0;
        end else if (w_flags.in_window && w_better) begin
            n_chosen_x    = w_x;
            n_chosen_y    = w_y;
            n_chosen_diff = w_diff;
            n_chosen_dist = w_dist;
        end
        o_res_push = o_mid_pop && w_flags.last;
        o_res_data = {n_chosen_x, n_chosen_y, n_chosen_diff};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chosen_x    <= '0;
            r_chosen_y    <= '0;
            r_chosen_diff <= wcvps_pkg::DIFF_RESET;
            r_chosen_dist <= '0;
        end else if (o_mid_pop) begin
            r_chosen_x    <= n_chosen_x;
            r_chosen_y    <= n_chosen_y;
            r_chosen_diff <= n_chosen_diff;
            r_chosen_dist <= n_chosen_dist;
        end
    end

endmodule

// ===== rtl/window_closest_value_pixel_search.sv =====
// path: a last item is registered in the middle queue and its result in the result queue
// throughput: one item per cycle while the two-entry input queue has room; the back part
//   takes one item per cycle too, but holds a last item while the result queue is full
// reset: synchronous, clears both queues, loads register reset values and
//   the search state (difference all ones, center and choice at the origin)
// ----------------------------------------------------------------------------
// window_closest_value_pixel_search
// finds the pixel in a window whose value is closest to a target value
// ----------------------------------------------------------------------------
module window_closest_value_pixel_search #(
    parameter int unsigned COORD_BITS       = 12,
    parameter int unsigned HALF_WINDOW_BITS = 6,
    localparam int unsigned CFG_W0          =
        (COORD_BITS > wcvps_pkg::VALUE_BITS) ? COORD_BITS : wcvps_pkg::VALUE_BITS,
    localparam int unsigned CFG_BITS        =
        (CFG_W0 > HALF_WINDOW_BITS) ? CFG_W0 : HALF_WINDOW_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [wcvps_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0]                  i_cfg_data,
    input  logic                                 push,
    output logic                                 full,
    input  logic                                 i_kind,
    input  logic [COORD_BITS-1:0]                i_pos_x,
    input  logic [COORD_BITS-1:0]                i_pos_y,
    input  logic [wcvps_pkg::VALUE_BITS-1:0]     i_pixel_value,
    input  logic                                 i_last_pixel,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [COORD_BITS-1:0]                o_best_x,
    output logic [COORD_BITS-1:0]                o_best_y,
    output logic [wcvps_pkg::VALUE_BITS-1:0]     o_best_difference
);

    localparam int unsigned VB        = wcvps_pkg::VALUE_BITS;
    localparam int unsigned DIST_BITS = 2 * HALF_WINDOW_BITS + 1;
    localparam int unsigned MID_BITS  =
        wcvps_pkg::FLAGS_BITS + 2 * COORD_BITS + VB + DIST_BITS;
    localparam int unsigned RES_BITS  = 2 * COORD_BITS + VB;
    localparam int unsigned Q_DEPTH   = 2;

    logic                  w_accept;
    wcvps_pkg::t_flags     w_flags;
    logic [VB-1:0]         w_diff;
    logic [DIST_BITS-1:0]  w_dist;
    logic [MID_BITS-1:0]   w_mid_in;
    logic [MID_BITS-1:0]   w_mid_out;
    logic                  w_mid_empty;
    logic                  w_mid_pop;
    logic                  w_res_full;
    logic                  w_res_push;
    logic [RES_BITS-1:0]   w_res_in;
    logic [RES_BITS-1:0]   w_res_out;

    assign w_accept = push && !full;
    assign w_mid_in = {w_flags, i_pos_x, i_pos_y, w_diff, w_dist};

    wcvps_front #(
        .COORD_BITS       (COORD_BITS),
        .HALF_WINDOW_BITS (HALF_WINDOW_BITS),
        .CFG_BITS         (CFG_BITS),
        .DIST_BITS        (DIST_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (w_accept),
        .i_kind        (i_kind),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pixel_value (i_pixel_value),
        .i_last_pixel  (i_last_pixel),
        .o_flags       (w_flags),
        .o_diff        (w_diff),
        .o_dist        (w_dist)
    );

    wcvps_queue #(
        .WIDTH (MID_BITS),
        .DEPTH (Q_DEPTH)
    ) u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_mid_in),
        .i_pop   (w_mid_pop),
        .o_data  (w_mid_out),
        .o_full  (full),
        .o_empty (w_mid_empty)
    );

    wcvps_back #(
        .COORD_BITS (COORD_BITS),
        .DIST_BITS  (DIST_BITS),
        .MID_BITS   (MID_BITS),
        .RES_BITS   (RES_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_data  (w_mid_out),
        .i_mid_empty (w_mid_empty),
        .o_mid_pop   (w_mid_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res_data  (w_res_in)
    );

    wcvps_queue #(
        .WIDTH (RES_BITS),
        .DEPTH (Q_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .i_pop   (pop),
        .o_data  (w_res_out),
        .o_full  (w_res_full),
        .o_empty (empty)
    );

    assign {o_best_x, o_best_y, o_best_difference} = w_res_out;

`ifndef SYNTH
    // a result is only produced when the result queue has room for it
    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> !w_res_full)
        else $error("result pushed into a full queue");

    // the back part never takes from an empty queue
    a_mid_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mid_pop |-> !w_mid_empty)
        else $error("back part popped an empty queue");

    // only a last item taken by the back part gives a result
    a_res_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> (w_mid_pop && u_back.w_flags.last))
        else $error("result without a last item");

    // both queues come out of reset empty
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full && w_mid_empty)
        else $error("queues not cleared by reset");
`endif

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the windowed closest-value pixel search. A short
// directed walk covers the window edges, frame clipping, ties on distance and
// results without a start item. Random searches then run under several
// window and frame settings. Every item is predicted in the bench and each
// result is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wcvps_pkg::*;

    localparam int COORD_BITS    = 12;
    localparam int HALF_BITS     = 6;
    localparam int CFG_W         = 12;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 130;
    localparam int CALM_PHASE    = 3;
    localparam int SQUEEZE_PHASE = 4;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [VALUE_BITS-1:0] value_t;
    typedef logic [2*HALF_BITS:0]  dist_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        value_t diff;
    } best_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_op_e;

    typedef struct packed {
        row_op_e                   op;
        logic [CFG_INDEX_BITS-1:0] index;
        logic [CFG_W-1:0]          data;
        logic                      kind;
        coord_t                    x;
        coord_t                    y;
        value_t                    value;
        logic                      last;
        logic                      typed;
        best_t                     want;
    } row_t;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_W-1:0]          cfg_data  = '0;
    logic                      push      = 1'b0;
    logic                      in_kind   = 1'b0;
    coord_t                    in_x      = '0;
    coord_t                    in_y      = '0;
    value_t                    in_value  = '0;
    logic                      in_last   = 1'b0;
    logic                      pop       = 1'b0;
    logic                      full;
    logic                      empty;
    coord_t                    out_x;
    coord_t                    out_y;
    value_t                    out_diff;

    window_closest_value_pixel_search u_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .push              (push),
        .full              (full),
        .i_kind            (in_kind),
        .i_pos_x           (in_x),
        .i_pos_y           (in_y),
        .i_pixel_value     (in_value),
        .i_last_pixel      (in_last),
        .empty             (empty),
        .pop               (pop),
        .o_best_x          (out_x),
        .o_best_y          (out_y),
        .o_best_difference (out_diff)
    );

    always #2 clk = ~clk;

    // search model: registers and running best candidate
    logic [HALF_BITS-1:0] win_hw    = HALF_BITS'(HALF_RESET);
    logic [HALF_BITS-1:0] win_hh    = HALF_BITS'(HALF_RESET);
    value_t               target    = TARGET_RESET;
    coord_t               frame_x   = '1;
    coord_t               frame_y   = '1;
    coord_t               ctr_x     = '0;
    coord_t               ctr_y     = '0;
    coord_t               pick_x    = '0;
    coord_t               pick_y    = '0;
    value_t               pick_diff = DIFF_RESET;
    dist_t                pick_dist = '0;

    best_t pending_best[$];
    row_t  plan[$];

    int  errors       = 0;
    int  items_sent   = 0;
    int  results_seen = 0;
    int  cycles       = 0;
    int  hold_left    = 0;
    bit  hold_done    = 1'b0;
    bit  calm         = 1'b0;
    bit  squeeze      = 1'b0;

    function automatic coord_t coord_gap(input coord_t a, input coord_t b);
        return (a >= b) ? a - b : b - a;
    endfunction

    task automatic search_step(input logic kind, input coord_t x, input coord_t y,
                               input value_t v, input logic last,
                               output logic emits, output best_t res);
        value_t diff;
        coord_t dx;
        coord_t dy;
        dist_t  sq_dist;
        diff = (v >= target) ? v - target : target - v;
        if (kind == KIND_START) begin
            ctr_x     = x;
            ctr_y     = y;
            pick_x    = x;
            pick_y    = y;
            pick_diff = diff;
            pick_dist = '0;
        end else begin
            dx = coord_gap(x, ctr_x);
            dy = coord_gap(y, ctr_y);
            if (dx <= win_hw && dy <= win_hh && x <= frame_x && y <= frame_y) begin
                sq_dist = dist_t'(int'(dx) * int'(dx) + int'(dy) * int'(dy));
                if (diff < pick_diff || (diff == pick_diff && sq_dist < pick_dist)) begin
                    pick_x    = x;
                    pick_y    = y;
                    pick_diff = diff;
                    pick_dist = sq_dist;
                end
            end
        end
        emits = last;
        res   = '{x: pick_x, y: pick_y, diff: pick_diff};
    endtask

    // one item, with a random gap in front unless the phase is calm
    task automatic offer(input logic k, input coord_t x, input coord_t y, input value_t v,
                         input logic last, input logic typed, input best_t want);
        logic  emits;
        best_t res;
        if (!calm && $urandom_range(0, 99) < 14) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        push     <= 1'b1;
        in_kind  <= k;
        in_x     <= x;
        in_y     <= y;
        in_value <= v;
        in_last  <= last;
        do @(posedge clk); while (full !== 1'b0);
        items_sent++;
        search_step(k, x, y, v, last, emits, res);
        if (emits) pending_best.push_back(typed ? want : res);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [CFG_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        case (idx)
            CFG_HALF_WIDTH:   win_hw  = d[HALF_BITS-1:0];
            CFG_HALF_HEIGHT:  win_hh  = d[HALF_BITS-1:0];
            CFG_TARGET_VALUE: target  = d[VALUE_BITS-1:0];
            CFG_FRAME_MAX_X:  frame_x = d[COORD_BITS-1:0];
            CFG_FRAME_MAX_Y:  frame_y = d[COORD_BITS-1:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // stop offering and let every result drain, then let the items that carry no result pass
    task automatic settle();
        push <= 1'b0;
        while (pending_best.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic add_item(input logic k, input int x, input int y, input int v,
                            input logic last);
        row_t r;
        r       = '0;
        r.op    = ROW_ITEM;
        r.kind  = k;
        r.x     = coord_t'(x);
        r.y     = coord_t'(y);
        r.value = value_t'(v);
        r.last  = last;
        plan.push_back(r);
    endtask

    task automatic add_checked(input logic k, input int x, input int y, input int v,
                               input int wx, input int wy, input int wd);
        add_item(k, x, y, v, 1'b1);
        plan[$].typed = 1'b1;
        plan[$].want  = '{x: coord_t'(wx), y: coord_t'(wy), diff: value_t'(wd)};
    endtask

    task automatic add_cfg(input logic [CFG_INDEX_BITS-1:0] idx, input int d);
        row_t r;
        r       = '0;
        r.op    = ROW_CFG;
        r.index = idx;
        r.data  = CFG_W'(d);
        plan.push_back(r);
    endtask

    function automatic value_t near_value();
        int v;
        if ($urandom_range(0, 1) == 0) return value_t'($urandom);
        v = int'(target) + int'($urandom_range(0, 4)) - 2;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return value_t'(v);
    endfunction

    function automatic int clamp_coord(input int c);
        if (c < 0) return 0;
        if (c > 4095) return 4095;
        return c;
    endfunction

    // one search: mostly a start, pixels around it and a closing last item;
    // sometimes pixels with no start, sometimes pure noise
    task automatic random_search();
        int   mode;
        int   n;
        int   cx;
        int   cy;
        int   px;
        int   py;
        logic last;
        mode = $urandom_range(0, 9);
        if (mode == 0) begin
            offer(logic'($urandom_range(0, 1)), coord_t'($urandom), coord_t'($urandom),
                  value_t'($urandom), $urandom_range(0, 3) == 0, 1'b0, '0);
            return;
        end
        if ($urandom_range(0, 7) == 0) begin
            cx = $urandom_range(0, 4095);
            cy = $urandom_range(0, 4095);
        end else begin
            cx = $urandom_range(0, frame_x);
            cy = $urandom_range(0, frame_y);
        end
        if (mode != 1) begin
            last = ($urandom_range(0, 9) == 0);
            offer(KIND_START, coord_t'(cx), coord_t'(cy), near_value(), last, 1'b0, '0);
            if (last) return;
        end
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                px = $urandom_range(0, 4095);
                py = $urandom_range(0, 4095);
            end else begin
                px = clamp_coord(cx + int'($urandom_range(0, 2 * win_hw + 2)) - int'(win_hw) - 1);
                py = clamp_coord(cy + int'($urandom_range(0, 2 * win_hh + 2)) - int'(win_hh) - 1);
            end
            offer(KIND_PIXEL, coord_t'(px), coord_t'(py), near_value(), i == n - 1, 1'b0, '0);
        end
    endtask

    // result side: compare, then decide whether to take the next one
    always @(posedge clk) begin
        best_t want;
        if (pop === 1'b1 && empty === 1'b0) begin
            results_seen++;
            if (pending_best.size() == 0) begin
                errors++;
                $error("unexpected result: best_x %0d best_y %0d best_difference %0d",
                       out_x, out_y, out_diff);
            end else begin
                want = pending_best.pop_front();
                if (out_x !== want.x) begin
                    errors++;
                    $error("best_x expected %0d got %0d", want.x, out_x);
                end
                if (out_y !== want.y) begin
                    errors++;
                    $error("best_y expected %0d got %0d", want.y, out_y);
                end
                if (out_diff !== want.diff) begin
                    errors++;
                    $error("best_difference expected %0d got %0d", want.diff, out_diff);
                end
            end
        end
        if (hold_left != 0) begin
            hold_left--;
        end else if (squeeze && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        pop <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= 22);
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_best.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int base;
        int hw;
        int hh;
        int fx;
        int fy;

        // pixel before any start, against the reset state
        add_checked(KIND_PIXEL, 3, 4, 0, 3, 4, 0);
        // start with last set emits the centre straight away
        add_checked(KIND_START, 100, 200, 10, 100, 200, 10);
        add_item(KIND_PIXEL, 107, 207, 5, 1'b0);    // window corner
        add_item(KIND_PIXEL, 108, 200, 0, 1'b0);    // one past the edge
        add_item(KIND_PIXEL, 100, 193, 5, 1'b0);    // same difference, closer
        add_item(KIND_PIXEL, 101, 200, 5, 1'b0);
        add_item(KIND_PIXEL, 99, 200, 5, 1'b0);     // equal distance keeps the old one
        add_item(KIND_PIXEL, 100, 207, 255, 1'b1);
        add_item(KIND_START, 0, 0, 255, 1'b0);
        // ignored last pixel still emits
        add_checked(KIND_PIXEL, 4095, 4095, 0, 0, 0, 255);
        add_item(KIND_START, 4095, 4095, 0, 1'b0);
        add_item(KIND_PIXEL, 4088, 4088, 0, 1'b0);
        add_checked(KIND_PIXEL, 4095, 4094, 128, 4095, 4095, 0);
        add_cfg(CFG_HALF_WIDTH, 63);
        add_cfg(CFG_HALF_HEIGHT, 0);
        add_cfg(CFG_TARGET_VALUE, 255);
        add_cfg(CFG_FRAME_MAX_X, 100);
        add_cfg(CFG_FRAME_MAX_Y, 50);
        add_item(KIND_START, 90, 50, 255, 1'b0);
        add_item(KIND_PIXEL, 101, 50, 255, 1'b0);   // right of the frame
        add_item(KIND_PIXEL, 95, 51, 255, 1'b0);    // below the frame
        add_checked(KIND_PIXEL, 27, 50, 255, 90, 50, 0);
        // centre outside the frame is still the seed
        add_item(KIND_START, 200, 60, 0, 1'b0);
        add_item(KIND_PIXEL, 150, 60, 200, 1'b0);
        add_checked(KIND_PIXEL, 100, 60, 1, 200, 60, 255);
        // state kept after a result
        add_item(KIND_PIXEL, 95, 50, 254, 1'b1);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i]) begin
            if (plan[i].op == ROW_CFG) begin
                settle();
                write_reg(plan[i].index, plan[i].data);
            end else begin
                offer(plan[i].kind, plan[i].x, plan[i].y, plan[i].value, plan[i].last,
                      plan[i].typed, plan[i].want);
            end
        end

        base = items_sent;
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            calm = 1'b0;
            case (ph)
                0: begin
                    hw = 63;
                    hh = 63;
                    fx = 4095;
                    fy = 4095;
                end
                1: begin
                    hw = 0;
                    hh = 0;
                    fx = 0;
                    fy = 0;
                end
                default: begin
                    hw = ($urandom_range(0, 5) == 0) ? 0 :
                         ($urandom_range(0, 4) == 0) ? 63 : $urandom_range(1, 12);
                    hh = ($urandom_range(0, 5) == 0) ? 0 :
                         ($urandom_range(0, 4) == 0) ? 63 : $urandom_range(1, 12);
                    fx = ($urandom_range(0, 3) == 0) ? 4095 : $urandom_range(16, 300);
                    fy = ($urandom_range(0, 3) == 0) ? 4095 : $urandom_range(0, 4095);
                end
            endcase
            write_reg(CFG_HALF_WIDTH, CFG_W'(hw));
            write_reg(CFG_HALF_HEIGHT, CFG_W'(hh));
            write_reg(CFG_TARGET_VALUE, (ph == 0) ? CFG_W'(255) :
                                        (ph == 1) ? CFG_W'(0) : CFG_W'($urandom_range(0, 255)));
            write_reg(CFG_FRAME_MAX_X, CFG_W'(fx));
            write_reg(CFG_FRAME_MAX_Y, CFG_W'(fy));
            calm    = (ph == CALM_PHASE);
            squeeze = (ph == SQUEEZE_PHASE);
            while (items_sent < base + (ph + 1) * PHASE_ITEMS) random_search();
        end

        calm = 1'b0;
        settle();
        repeat (16) @(posedge clk);
        $display("%0d items over %0d register settings, %0d results compared",
                 items_sent, PHASES + 2, results_seen);
        $display("windows 0 to 63, frames down to the origin, output hold-off and drains");
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
